>>> rtl/core/qtd_pkg.sv
// ----------------------------------------------------------------------------
// qtd_pkg
// Shared types and constants for the quadtree token decoder.
// ----------------------------------------------------------------------------
package qtd_pkg;

  localparam int MAX_ORDER = 10;
  localparam int LVL_W     = $clog2(MAX_ORDER + 1);
  localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  localparam int TOKEN_W   = 8;
  localparam int ORDER_W   = 4;
  localparam int FILL_XY_W = 10;
  localparam int FILL_LS_W = 4;

  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ORDER = '0;
  localparam logic [ORDER_W-1:0]   IMAGE_ORDER_RST = 4'd3;

  localparam logic [TOKEN_W-1:0] TOK_OPEN = 8'h28;
  localparam logic [TOKEN_W-1:0] TOK_ONE  = 8'h31;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_TR = 2'd0;
  localparam quad_t QUAD_TL = 2'd1;
  localparam quad_t QUAD_BL = 2'd2;
  localparam quad_t QUAD_BR = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] order;
    logic             restart;
  } cfg_ctl_t;

  typedef struct packed {
    logic [FILL_XY_W-1:0] x;
    logic [FILL_XY_W-1:0] y;
    logic [FILL_LS_W-1:0] log_size;
    logic                 value;
    logic                 last;
    logic                 malformed;
  } fill_t;

endpackage

>>> rtl/core/qtd_in_if.sv
// ----------------------------------------------------------------------------
// qtd_in_if
// Token channel: valid/ready handshake with one 8-bit token per transaction.
// ----------------------------------------------------------------------------
interface qtd_in_if;
  import qtd_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token;

  modport source (output valid, output token, input ready);
  modport sink   (input valid, input token, output ready);
endinterface

>>> rtl/core/qtd_out_if.sv
// ----------------------------------------------------------------------------
// qtd_out_if
// Fill channel: valid/ready handshake with one square fill per transaction.
// ----------------------------------------------------------------------------
interface qtd_out_if;
  import qtd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FILL_XY_W-1:0] fill_x;
  logic [FILL_XY_W-1:0] fill_y;
  logic [FILL_LS_W-1:0] fill_log_size;
  logic                 fill_value;
  logic                 image_last;
  logic                 malformed;

  modport source (output valid, output fill_x, output fill_y, output fill_log_size,
                  output fill_value, output image_last, output malformed, input ready);
  modport sink   (input valid, input fill_x, input fill_y, input fill_log_size,
                  input fill_value, input image_last, input malformed, output ready);
endinterface

>>> rtl/core/qtd_cfg.sv
// ----------------------------------------------------------------------------
// qtd_cfg
// APB register file: image_order, clamped to MAX_ORDER; a write restarts
// the walker at the root.
// ----------------------------------------------------------------------------
module qtd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qtd_pkg::APB_AW-1:0]   paddr,
  input  logic [qtd_pkg::APB_DW-1:0]   pwdata,
  output logic [qtd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output qtd_pkg::cfg_ctl_t            ctl
);
  import qtd_pkg::*;

  logic [ORDER_W-1:0] order_r;
  logic               hit;
  logic               wr;

  assign hit    = (paddr[APB_AW-1:2] == REG_IMAGE_ORDER);
  assign wr     = psel & penable & pwrite & hit;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= IMAGE_ORDER_RST;
    end else if (wr) begin
      order_r <= pwdata[ORDER_W-1:0];
    end
  end

  assign prdata = hit ? APB_DW'(order_r) : '0;

  always_comb begin
    ctl.restart = wr;
    if (int'(order_r) > MAX_ORDER) begin
      ctl.order = LVL_W'(MAX_ORDER);
    end else begin
      ctl.order = LVL_W'(order_r);
    end
  end

endmodule

>>> rtl/core/qtd_istage.sv
// ----------------------------------------------------------------------------
// qtd_istage
// Input register for the token channel.
// ----------------------------------------------------------------------------
module qtd_istage (
  input  logic                        clk,
  input  logic                        rst_n,
  qtd_in_if.sink                      in_chan,
  input  logic                        take,
  output logic                        tok_valid_r,
  output logic [qtd_pkg::TOKEN_W-1:0] tok_r
);
  import qtd_pkg::*;

  logic fire;

  assign in_chan.ready = !tok_valid_r || take;
  assign fire          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (fire) begin
      tok_valid_r <= 1'b1;
    end else if (take) begin
      tok_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tok_r <= in_chan.token;
    end
  end

endmodule

>>> rtl/core/qtd_walk.sv
// ----------------------------------------------------------------------------
// qtd_walk
// Quadtree walker: quadrant path, depth and closer count; decodes one
// token per step into a push, a closer skip or a leaf fill.
// ----------------------------------------------------------------------------
module qtd_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qtd_pkg::cfg_ctl_t           cfg,
  input  logic                        step,
  input  logic [qtd_pkg::TOKEN_W-1:0] token,
  output logic                        emit,
  output qtd_pkg::fill_t              fill
);
  import qtd_pkg::*;

  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [LVL_W-1:0]     pend_r, pend_nxt;
  quad_t                stack_r   [MAX_ORDER];
  quad_t                stack_nxt [MAX_ORDER];

  logic                 is_open;
  logic                 push;
  logic                 last;
  logic [IDX_W-1:0]     top_idx;
  logic [MAX_ORDER-1:0] cx, cy;
  logic [LVL_W-1:0]     pos;
  quad_t                q;

  assign is_open = (token == TOK_OPEN);
  assign push    = (pend_r == '0) && is_open && (level_r < cfg.order);
  assign emit    = step && (pend_r == '0) && !push;

  // corner of the current node from the quadrant path
  always_comb begin
    cx  = '0;
    cy  = '0;
    pos = '0;
    q   = QUAD_TR;
    for (int b = 0; b < MAX_ORDER; b++) begin
      pos = LVL_W'(int'(cfg.order) - 1 - b);
      if (b < int'(cfg.order) && b >= int'(cfg.order) - int'(level_r)) begin
        q     = stack_r[pos[IDX_W-1:0]];
        cx[b] = (q == QUAD_TR) || (q == QUAD_BR);
        cy[b] = (q == QUAD_BL) || (q == QUAD_BR);
      end
    end
  end

  // deepest ancestor that still has a sibling to visit
  always_comb begin
    last    = 1'b1;
    top_idx = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (i < int'(level_r) && stack_r[i] != QUAD_BR) begin
        last    = 1'b0;
        top_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    fill.x         = FILL_XY_W'(cx);
    fill.y         = FILL_XY_W'(cy);
    fill.log_size  = FILL_LS_W'(cfg.order - level_r);
    fill.value     = !is_open && (token == TOK_ONE);
    fill.last      = last;
    fill.malformed = is_open;
  end

  always_comb begin
    level_nxt = level_r;
    pend_nxt  = pend_r;
    stack_nxt = stack_r;
    if (cfg.restart) begin
      level_nxt = '0;
      pend_nxt  = '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        stack_nxt[i] = QUAD_TR;
      end
    end else if (step) begin
      if (pend_r != '0) begin
        pend_nxt = pend_r - LVL_W'(1);
      end else if (push) begin
        stack_nxt[level_r[IDX_W-1:0]] = QUAD_TR;
        level_nxt                     = level_r + LVL_W'(1);
      end else if (last) begin
        level_nxt = '0;
        pend_nxt  = level_r;
        for (int i = 0; i < MAX_ORDER; i++) begin
          stack_nxt[i] = QUAD_TR;
        end
      end else begin
        level_nxt          = LVL_W'(top_idx) + LVL_W'(1);
        pend_nxt           = level_r - LVL_W'(top_idx) - LVL_W'(1);
        stack_nxt[top_idx] = stack_r[top_idx] + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      pend_r  <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        stack_r[i] <= QUAD_TR;
      end
    end else begin
      level_r <= level_nxt;
      pend_r  <= pend_nxt;
      stack_r <= stack_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= cfg.order)
    else $error("walker depth beyond image order");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pend_r) <= MAX_ORDER)
    else $error("closer count beyond tree depth");

  a_no_fill_on_closer: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> !emit)
    else $error("fill issued while closers pending");

  a_last_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (level_r == '0))
    else $error("walker not at root after last leaf");

  a_push_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && push && !cfg.restart) |=> (level_r == $past(level_r) + LVL_W'(1)))
    else $error("open token did not descend");
`endif

endmodule

>>> rtl/core/qtd_ostage.sv
// ----------------------------------------------------------------------------
// qtd_ostage
// Result register for the fill channel.
// ----------------------------------------------------------------------------
module qtd_ostage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qtd_pkg::fill_t fill_i,
  output logic           room,
  qtd_out_if.source      out_chan
);
  import qtd_pkg::*;

  logic  valid_r;
  fill_t fill_r;

  assign room = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fill_r <= fill_i;
    end
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.fill_x        = fill_r.x;
  assign out_chan.fill_y        = fill_r.y;
  assign out_chan.fill_log_size = fill_r.log_size;
  assign out_chan.fill_value    = fill_r.value;
  assign out_chan.image_last    = fill_r.last;
  assign out_chan.malformed     = fill_r.malformed;

endmodule

>>> rtl/core/quadtree_token_decoder.sv
// A token is held in the token register and its fill in the fill register; the walker between them is combinational.
// One token per cycle while the fill register has room; the walker decodes a token combinationally.
// Closer tokens and open tokens that descend produce no fill; the token register stalls only
// while the fill register is full and not drained.
// Reset (rst_n low, synchronous): walker at the root, no closers pending,
// both registers empty, image_order = 3. An image_order write also restarts.
// ----------------------------------------------------------------------------
// quadtree_token_decoder
// Region quadtree token stream to square fills, one token per cycle while the fill register has room.
// ----------------------------------------------------------------------------
module quadtree_token_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  qtd_in_if.sink                     in_chan,
  qtd_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qtd_pkg::APB_AW-1:0] paddr,
  input  logic [qtd_pkg::APB_DW-1:0] pwdata,
  output logic [qtd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import qtd_pkg::*;

  cfg_ctl_t           cfg;
  logic               tok_valid_r;
  logic [TOKEN_W-1:0] tok_r;
  logic               room;
  logic               take;
  logic               emit;
  fill_t              fill;

  assign take = tok_valid_r && room;

  qtd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (cfg)
  );

  qtd_istage u_istage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .take        (take),
    .tok_valid_r (tok_valid_r),
    .tok_r       (tok_r)
  );

  qtd_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (take),
    .token (tok_r),
    .emit  (emit),
    .fill  (fill)
  );

  qtd_ostage u_ostage (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (emit),
    .fill_i   (fill),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule
